/* hw/rtl/lbm_d2q9_bgk_collision_core_assert.svh */
// Assertion macros shared by the collision core checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef LBM_D2Q9_BGK_COLLISION_CORE_ASSERT_SVH
`define LBM_D2Q9_BGK_COLLISION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LBMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbmc: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LBMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbmc: next-cycle check failed");

`endif

/* hw/rtl/lbmc_pkg.sv */
// Shared types, register codes and fixed-point helpers for the D2Q9 collision core.
// No dependencies; every other RTL file but the assertion header uses this package.
`default_nettype none

package lbmc_pkg;

  localparam int NDIR = 9;
  localparam int QW   = 32;

  typedef logic signed [QW-1:0] q_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_INV_TAU = 2'd0;
  localparam logic [1:0] REG_GRAV_X  = 2'd1;
  localparam logic [1:0] REG_GRAV_Y  = 2'd2;

  localparam logic [29:0] ITAU_RESET = 30'd223696213;

  // Lattice directions: rest, E, N, W, S, NE, NW, SW, SE.
  localparam int DX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  localparam logic signed [64:0] SMAX65 = 65'sd2147483647;
  localparam logic signed [64:0] SMIN65 = -65'sd2147483648;

  typedef struct packed {
    logic [NDIR-1:0][QW-1:0] f;
    logic [QW-1:0]           rho;
    logic [QW-1:0]           fx;
    logic [QW-1:0]           fy;
    logic                    wall;
    logic                    bad;
  } side_t;

  typedef struct packed {
    logic [NDIR-1:0][QW-1:0] d;
    logic                    bad;
  } word_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [30:0] rem;
    logic [31:0] num;
    logic [32:0] q;
    logic        big;
    logic        neg;
  } lane_t;

  function automatic q_t sat65(input logic signed [64:0] v);
    q_t r;
    if (v > SMAX65) begin
      r = 32'sh7fffffff;
    end else if (v < SMIN65) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Fixed-point product, rounded to nearest with ties up, saturated.
  function automatic q_t rmul(input q_t a, input q_t b, input int frac);
    logic signed [63:0] p;
    logic signed [64:0] s;
    p = a * b;
    s = 65'(p) + (65'sd1 <<< (frac - 1));
    return sat65(s >>> frac);
  endfunction

  // Projection of (a, b) on a lattice direction, saturated.
  function automatic q_t dir_dot(input int dx, input int dy, input q_t a, input q_t b);
    logic signed [64:0] s;
    s = '0;
    if (dx == 1) begin
      s = s + 65'(a);
    end else if (dx == -1) begin
      s = s - 65'(a);
    end
    if (dy == 1) begin
      s = s + 65'(b);
    end else if (dy == -1) begin
      s = s - 65'(b);
    end
    return sat65(s);
  endfunction

  function automatic lane_t lane_init(input q_t j);
    lane_t      l;
    logic [32:0] m;
    m = j[31] ? -(33'(j)) : 33'(j);
    l.rem = '0;
    l.num = m[31:0];
    l.q   = '0;
    l.big = 1'b0;
    l.neg = j[31];
    return l;
  endfunction

  // One quotient bit; a quotient above 2^31 is clamped to 2^31.
  function automatic lane_t div_step(input lane_t l, input logic [30:0] d);
    lane_t       n;
    logic [31:0] r2;
    logic        ge;
    logic [32:0] qn;
    r2    = {l.rem, l.num[31]};
    ge    = (r2 >= {1'b0, d});
    n     = l;
    n.rem = ge ? 31'(r2 - {1'b0, d}) : r2[30:0];
    n.num = {l.num[30:0], 1'b0};
    qn    = {l.q[31:0], ge};
    n.q   = qn;
    n.big = l.big | (qn > 33'h0_8000_0000);
    return n;
  endfunction

  function automatic q_t lane_fin(input lane_t l);
    logic [32:0] m;
    logic [32:0] nm;
    q_t          r;
    m  = l.big ? 33'h0_8000_0000 : l.q;
    nm = -m;
    if (l.neg) begin
      r = nm[31:0];
    end else if (m > 33'h0_7fff_ffff) begin
      r = 32'sh7fffffff;
    end else begin
      r = m[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lbmc_moments.sv */
// Density, momentum and body force of one cell, five register stages.
// Depends on lbmc_pkg.
`default_nettype none

module lbmc_moments #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [lbmc_pkg::NDIR-1:0][lbmc_pkg::QW-1:0] in_f,
  input  logic                                      in_wall,
  input  lbmc_pkg::q_t                              grav_x,
  input  lbmc_pkg::q_t                              grav_y,
  output logic                                      out_valid,
  output lbmc_pkg::q_t                              out_jx,
  output lbmc_pkg::q_t                              out_jy,
  output lbmc_pkg::side_t                           out_side
);
  import lbmc_pkg::*;

  localparam longint QONE = 64'sd1 <<< FRAC_BITS;
  localparam q_t     HALF = sat65(65'((2 * QONE + 2) / 4));

  logic v_r [5];

  // Stage 1: partial sums.
  logic signed [33:0] ra_r, rb_r, rc_r, xa_r, xb_r, ya_r, yb_r;
  logic [NDIR-1:0][QW-1:0] f1_r;
  logic wall1_r;

  // Stage 2: saturated moments.
  q_t rho2_r, jx2_r, jy2_r;
  q_t rho2_nxt, jx2_nxt, jy2_nxt;
  logic [NDIR-1:0][QW-1:0] f2_r;
  logic wall2_r;

  // Stage 3: force.
  q_t fx3_r, fy3_r, rho3_r, jx3_r, jy3_r;
  logic [NDIR-1:0][QW-1:0] f3_r;
  logic wall3_r;

  // Stage 4: half force.
  q_t hx4_r, hy4_r, fx4_r, fy4_r, rho4_r, jx4_r, jy4_r;
  logic [NDIR-1:0][QW-1:0] f4_r;
  logic wall4_r;

  // Stage 5: corrected momentum.
  q_t jx5_r, jy5_r;
  side_t side5_r;
  q_t jx5_nxt, jy5_nxt;
  side_t side5_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r <= 34'(signed'(in_f[0])) + 34'(signed'(in_f[1])) + 34'(signed'(in_f[2]));
      rb_r <= 34'(signed'(in_f[3])) + 34'(signed'(in_f[4])) + 34'(signed'(in_f[5]));
      rc_r <= 34'(signed'(in_f[6])) + 34'(signed'(in_f[7])) + 34'(signed'(in_f[8]));
      xa_r <= 34'(signed'(in_f[1])) - 34'(signed'(in_f[3])) + 34'(signed'(in_f[5]));
      xb_r <= 34'(signed'(in_f[8])) - 34'(signed'(in_f[6])) - 34'(signed'(in_f[7]));
      ya_r <= 34'(signed'(in_f[2])) - 34'(signed'(in_f[4])) + 34'(signed'(in_f[5]));
      yb_r <= 34'(signed'(in_f[6])) - 34'(signed'(in_f[7])) - 34'(signed'(in_f[8]));
      f1_r    <= in_f;
      wall1_r <= in_wall;
    end
  end

  always_comb begin
    rho2_nxt = sat65(65'(ra_r) + 65'(rb_r) + 65'(rc_r));
    jx2_nxt  = sat65(65'(xa_r) + 65'(xb_r));
    jy2_nxt  = sat65(65'(ya_r) + 65'(yb_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rho2_r  <= rho2_nxt;
      jx2_r   <= jx2_nxt;
      jy2_r   <= jy2_nxt;
      f2_r    <= f1_r;
      wall2_r <= wall1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx3_r   <= rmul(grav_x, rho2_r, FRAC_BITS);
      fy3_r   <= rmul(grav_y, rho2_r, FRAC_BITS);
      rho3_r  <= rho2_r;
      jx3_r   <= jx2_r;
      jy3_r   <= jy2_r;
      f3_r    <= f2_r;
      wall3_r <= wall2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx4_r   <= rmul(fx3_r, HALF, FRAC_BITS);
      hy4_r   <= rmul(fy3_r, HALF, FRAC_BITS);
      fx4_r   <= fx3_r;
      fy4_r   <= fy3_r;
      rho4_r  <= rho3_r;
      jx4_r   <= jx3_r;
      jy4_r   <= jy3_r;
      f4_r    <= f3_r;
      wall4_r <= wall3_r;
    end
  end

  always_comb begin
    jx5_nxt        = sat65(65'(jx4_r) + 65'(hx4_r));
    jy5_nxt        = sat65(65'(jy4_r) + 65'(hy4_r));
    side5_nxt.f    = f4_r;
    side5_nxt.rho  = rho4_r;
    side5_nxt.fx   = fx4_r;
    side5_nxt.fy   = fy4_r;
    side5_nxt.wall = wall4_r;
    side5_nxt.bad  = rho4_r[31] | (rho4_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jx5_r   <= jx5_nxt;
      jy5_r   <= jy5_nxt;
      side5_r <= side5_nxt;
    end
  end

  assign out_valid = v_r[4];
  assign out_jx    = jx5_r;
  assign out_jy    = jy5_r;
  assign out_side  = side5_r;

endmodule

`default_nettype wire

/* hw/rtl/lbmc_div.sv */
// Two-lane pipelined restoring divider for velocity = momentum / density.
// One quotient bit per stage; depends on lbmc_pkg.
`default_nettype none

module lbmc_div #(
  parameter int FRAC_BITS = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  lbmc_pkg::q_t    in_jx,
  input  lbmc_pkg::q_t    in_jy,
  input  lbmc_pkg::side_t in_side,
  output logic            out_valid,
  output lbmc_pkg::q_t    out_ux,
  output lbmc_pkg::q_t    out_uy,
  output lbmc_pkg::side_t out_side
);
  import lbmc_pkg::*;

  // The numerator is the 32-bit magnitude followed by FRAC_BITS zeros.
  localparam int NSTEP = QW + FRAC_BITS;

  lane_t lx_r [NSTEP];
  lane_t ly_r [NSTEP];
  side_t sd_r [NSTEP];
  logic  v_r  [NSTEP];

  q_t    ux_r, uy_r;
  side_t sdo_r;
  logic  vo_r;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    lane_t px, py, lx_nxt, ly_nxt;
    side_t ps;
    logic  pv;

    if (k == 0) begin : g_head
      assign px = lane_init(in_jx);
      assign py = lane_init(in_jy);
      assign ps = in_side;
      assign pv = in_valid;
    end else begin : g_body
      assign px = lx_r[k-1];
      assign py = ly_r[k-1];
      assign ps = sd_r[k-1];
      assign pv = v_r[k-1];
    end

    assign lx_nxt = div_step(px, ps.rho[30:0]);
    assign ly_nxt = div_step(py, ps.rho[30:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[k] <= lx_nxt;
        ly_r[k] <= ly_nxt;
        sd_r[k] <= ps;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= lane_fin(lx_r[NSTEP-1]);
      uy_r  <= lane_fin(ly_r[NSTEP-1]);
      sdo_r <= sd_r[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NSTEP-1];
    end
  end

  assign out_valid = vo_r;
  assign out_ux    = ux_r;
  assign out_uy    = uy_r;
  assign out_side  = sdo_r;

endmodule

`default_nettype wire

/* hw/rtl/lbmc_relax.sv */
// Equilibrium, forcing term and BGK relaxation for the nine directions.
// Seven register stages; depends on lbmc_pkg.
`default_nettype none

module lbmc_relax #(
  parameter int FRAC_BITS = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  lbmc_pkg::q_t    in_ux,
  input  lbmc_pkg::q_t    in_uy,
  input  lbmc_pkg::side_t in_side,
  input  logic [29:0]     inv_tau,
  output logic            out_valid,
  output lbmc_pkg::word_t out_word
);
  import lbmc_pkg::*;

  localparam longint QONE = 64'sd1 <<< FRAC_BITS;
  localparam q_t ONE  = sat65(65'(QONE));
  localparam q_t HALF = sat65(65'((2 * QONE + 2) / 4));
  localparam q_t C45  = sat65(65'((18 * QONE + 2) / 4));
  localparam q_t C15  = sat65(65'((6 * QONE + 2) / 4));
  localparam q_t W49  = sat65(65'((8 * QONE + 9) / 18));
  localparam q_t W19  = sat65(65'((2 * QONE + 9) / 18));
  localparam q_t W136 = sat65(65'((2 * QONE + 36) / 72));
  localparam q_t WQ [NDIR] = '{W49, W19, W19, W19, W19, W136, W136, W136, W136};

  q_t itau_q, omt_q;
  assign itau_q = {2'b00, inv_tau};
  assign omt_q  = sat65(65'(ONE) - 65'(itau_q));

  logic v_r [7];

  // Stage 1
  q_t pxx_r, pyy_r, pxf_r, pyf_r, th_r;
  q_t ud1_r [NDIR], fd1_r [NDIR], rw1_r [NDIR];
  side_t sd1_r;
  // Stage 2
  q_t u2_r, uf_r, coef2_r;
  q_t q1_r [NDIR], q2_r [NDIR], ud2_r [NDIR], fd2_r [NDIR], rw2_r [NDIR];
  side_t sd2_r;
  // Stage 3
  q_t b3_r, coef3_r;
  q_t a3_r [NDIR], term3_r [NDIR], ud3_r [NDIR], rw3_r [NDIR];
  side_t sd3_r;
  // Stage 4
  q_t coef4_r;
  q_t poly4_r [NDIR], wt4_r [NDIR], rw4_r [NDIR];
  side_t sd4_r;
  // Stage 5
  q_t feq5_r [NDIR], frc5_r [NDIR], keep5_r [NDIR], rw5_r [NDIR];
  side_t sd5_r;
  // Stage 6
  q_t a6_r [NDIR], frc6_r [NDIR], keep6_r [NDIR], rw6_r [NDIR];
  side_t sd6_r;
  // Stage 7
  word_t wo_r, wo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 7; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < 7; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= rmul(in_ux, in_ux, FRAC_BITS);
      pyy_r <= rmul(in_uy, in_uy, FRAC_BITS);
      pxf_r <= rmul(in_ux, in_side.fx, FRAC_BITS);
      pyf_r <= rmul(in_uy, in_side.fy, FRAC_BITS);
      th_r  <= rmul(itau_q, HALF, FRAC_BITS);
      for (int i = 0; i < NDIR; i++) begin
        ud1_r[i] <= dir_dot(DX[i], DY[i], in_ux, in_uy);
        fd1_r[i] <= dir_dot(DX[i], DY[i], in_side.fx, in_side.fy);
        rw1_r[i] <= rmul(in_side.rho, WQ[i], FRAC_BITS);
      end
      sd1_r <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r    <= sat65(65'(pxx_r) + 65'(pyy_r));
      uf_r    <= sat65(65'(pxf_r) + 65'(pyf_r));
      coef2_r <= sat65(65'sd3 * (65'(ONE) - 65'(th_r)));
      for (int i = 0; i < NDIR; i++) begin
        q1_r[i]  <= rmul(ud1_r[i], ud1_r[i], FRAC_BITS);
        q2_r[i]  <= rmul(ud1_r[i], fd1_r[i], FRAC_BITS);
        ud2_r[i] <= ud1_r[i];
        fd2_r[i] <= fd1_r[i];
        rw2_r[i] <= rw1_r[i];
      end
      sd2_r <= sd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_r    <= rmul(C15, u2_r, FRAC_BITS);
      coef3_r <= coef2_r;
      for (int i = 0; i < NDIR; i++) begin
        a3_r[i]    <= rmul(C45, q1_r[i], FRAC_BITS);
        term3_r[i] <= sat65(65'(fd2_r[i]) - 65'(uf_r) + 65'sd3 * 65'(q2_r[i]));
        ud3_r[i]   <= ud2_r[i];
        rw3_r[i]   <= rw2_r[i];
      end
      sd3_r <= sd2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef4_r <= coef3_r;
      for (int i = 0; i < NDIR; i++) begin
        poly4_r[i] <= sat65(65'(ONE) + 65'sd3 * 65'(ud3_r[i]) + 65'(a3_r[i]) - 65'(b3_r));
        wt4_r[i]   <= rmul(WQ[i], term3_r[i], FRAC_BITS);
        rw4_r[i]   <= rw3_r[i];
      end
      sd4_r <= sd3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NDIR; i++) begin
        feq5_r[i]  <= rmul(rw4_r[i], poly4_r[i], FRAC_BITS);
        frc5_r[i]  <= rmul(coef4_r, wt4_r[i], FRAC_BITS);
        keep5_r[i] <= rmul(omt_q, sd4_r.f[i], FRAC_BITS);
        rw5_r[i]   <= rw4_r[i];
      end
      sd5_r <= sd4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NDIR; i++) begin
        a6_r[i]    <= rmul(itau_q, feq5_r[i], FRAC_BITS);
        frc6_r[i]  <= frc5_r[i];
        keep6_r[i] <= keep5_r[i];
        rw6_r[i]   <= rw5_r[i];
      end
      sd6_r <= sd5_r;
    end
  end

  // A cell with no positive density passes through; a wall cell takes rho * w.
  always_comb begin
    wo_nxt.bad = sd6_r.bad;
    for (int i = 0; i < NDIR; i++) begin
      if (sd6_r.bad) begin
        wo_nxt.d[i] = sd6_r.f[i];
      end else if (sd6_r.wall) begin
        wo_nxt.d[i] = rw6_r[i];
      end else begin
        wo_nxt.d[i] = sat65(65'(keep6_r[i]) + 65'(a6_r[i]) + 65'(frc6_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wo_r <= wo_nxt;
    end
  end

  assign out_valid = v_r[6];
  assign out_word  = wo_r;

endmodule

`default_nettype wire

/* hw/rtl/lbm_d2q9_bgk_collision_core.sv */
// Top level of the D2Q9 BGK collision core with Guo forcing.
// Depends on lbmc_pkg, lbmc_moments, lbmc_div and lbmc_relax.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tdata: nine distributions; tuser: wall flag
//   out_     out  out_tvalid/out_tready tdata: nine distributions; tuser: bad density
//   cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// One word enters per cycle while the skid word is empty; the divider, which resolves
// one quotient bit per stage, holds most of the pipeline's registers.
// Reset is synchronous: it empties the pipeline and restores the register defaults.
// The output register is backed by one skid word; the pipeline freezes only while
// the skid word is occupied, so nothing is dropped or repeated under back-pressure.
`default_nettype none

module lbm_d2q9_bgk_collision_core #(
  parameter int FRAC_BITS = 28
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // dist_in_rest, _east, _north, _west, _south, _ne, _nw, _sw, _se
  input  logic [lbmc_pkg::NDIR*lbmc_pkg::QW-1:0] in_tdata,
  // wall_cell
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // dist_out_rest, _east, _north, _west, _south, _ne, _nw, _sw, _se
  output logic [lbmc_pkg::NDIR*lbmc_pkg::QW-1:0] out_tdata,
  // bad_density
  output logic                                   out_tuser,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_addr,
  input  logic [31:0]                            cfg_wdata
);
  import lbmc_pkg::*;

  logic [29:0] itau_r;
  q_t          gx_r, gy_r;

  logic en;

  logic  m_valid;
  q_t    m_jx, m_jy;
  side_t m_side;

  logic  d_valid;
  q_t    d_ux, d_uy;
  side_t d_side;

  logic  p_valid;
  word_t p_word;

  logic  ov_r, sk_v_r;
  word_t od_r, sk_d_r;

  logic [NDIR-1:0][QW-1:0] in_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itau_r <= ITAU_RESET;
      gx_r   <= '0;
      gy_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INV_TAU: itau_r <= cfg_wdata[29:0];
        REG_GRAV_X:  gx_r   <= cfg_wdata;
        REG_GRAV_Y:  gy_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !sk_v_r;
  assign in_tready = en;
  assign in_f      = in_tdata;

  lbmc_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_f     (in_f),
    .in_wall  (in_tuser),
    .grav_x   (gx_r),
    .grav_y   (gy_r),
    .out_valid(m_valid),
    .out_jx   (m_jx),
    .out_jy   (m_jy),
    .out_side (m_side)
  );

  lbmc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m_valid),
    .in_jx    (m_jx),
    .in_jy    (m_jy),
    .in_side  (m_side),
    .out_valid(d_valid),
    .out_ux   (d_ux),
    .out_uy   (d_uy),
    .out_side (d_side)
  );

  lbmc_relax #(.FRAC_BITS(FRAC_BITS)) u_relax (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_valid),
    .in_ux    (d_ux),
    .in_uy    (d_uy),
    .in_side  (d_side),
    .inv_tau  (itau_r),
    .out_valid(p_valid),
    .out_word (p_word)
  );

  // The skid word catches the one result that leaves the pipeline in the
  // cycle the output stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else if (!ov_r || out_tready) begin
      if (sk_v_r) begin
        ov_r   <= 1'b1;
        sk_v_r <= 1'b0;
      end else begin
        ov_r <= p_valid;
      end
    end else if (en && p_valid) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_tready) begin
      od_r <= sk_v_r ? sk_d_r : p_word;
    end
    if (ov_r && !out_tready && en) begin
      sk_d_r <= p_word;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r.d;
  assign out_tuser  = od_r.bad;

endmodule

`default_nettype wire

/* hw/rtl/lbmc_checker.sv */
// Port-level checks for the collision core, attached by bind.
// Depends on lbm_d2q9_bgk_collision_core_assert.svh and lbmc_pkg.
`default_nettype none
`include "lbm_d2q9_bgk_collision_core_assert.svh"

module lbmc_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [lbmc_pkg::NDIR*lbmc_pkg::QW-1:0] out_tdata,
  input logic                                   out_tuser
);

  // A stalled output word holds.
  `LBMC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // The skid word is only ever occupied behind a valid output word.
  `LBMC_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready)

  // Taking the output word always frees the skid word.
  `LBMC_ASSERT_NEXT(a_ready_after_take, out_tvalid && out_tready, in_tready)

endmodule

bind lbm_d2q9_bgk_collision_core lbmc_checker u_lbmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the D2Q9 BGK collision core with Guo forcing.
// Depends on lbmc_pkg and lbm_d2q9_bgk_collision_core; a scoreboard class predicts each cell.
`default_nettype none

module testbench;
  import lbmc_pkg::*;

  localparam int FRAC = 28;
  localparam int LATENCY = FRAC + 46;

  typedef struct {
    logic signed [31:0] d [9];
    logic               flag;
  } cell_t;

  class collision_scoreboard;
    longint inv_tau_q;
    longint grav_x_q;
    longint grav_y_q;
    cell_t  pending [$];
    int     errors;

    function new();
      inv_tau_q = 223696213;
      grav_x_q  = 0;
      grav_y_q  = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_INV_TAU) inv_tau_q = longint'(val[29:0]);
      else if (idx == REG_GRAV_X) grav_x_q = longint'($signed(val));
      else if (idx == REG_GRAV_Y) grav_y_q = longint'($signed(val));
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint wconst(longint n, longint d);
      return clamp((2 * n * (64'sd1 <<< FRAC) + d) / (2 * d));
    endfunction

    // Rounded product; the 64-bit product of two 32-bit values never overflows.
    function longint qmul(longint a, longint b);
      longint p;
      p = clamp(a) * clamp(b) + (64'sd1 <<< (FRAC - 1));
      return clamp(p >>> FRAC);
    endfunction

    function longint qdiv(longint j, longint r);
      longint unsigned cap, mag, q, rem;
      cap = 64'd1 << 31;
      mag = (j < 0) ? -j : j;
      q = mag / r;
      rem = mag % r;
      if (q > cap) q = cap;
      for (int k = 0; k < FRAC; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= r) begin
          rem = rem - r;
          q = q | 1;
        end
        if (q > cap) q = cap;
      end
      return clamp((j < 0) ? -longint'(q) : longint'(q));
    endfunction

    function void note_cell(cell_t c);
      cell_t  e;
      longint f [9];
      longint rho, jx, jy, fx, fy, ux, uy, u2, uf, coef, one, half, c45, c15;
      longint w, ud, fd, poly, feq, term, frc;
      rho = 0;
      jx = 0;
      jy = 0;
      one = 64'sd1 <<< FRAC;
      half = wconst(1, 2);
      c45 = wconst(9, 2);
      c15 = wconst(3, 2);
      for (int i = 0; i < 9; i++) begin
        f[i] = c.d[i];
        rho += f[i];
        jx += DX[i] * f[i];
        jy += DY[i] * f[i];
      end
      rho = clamp(rho);
      e.flag = 1'b0;
      if (rho <= 0) begin
        e.flag = 1'b1;
        for (int i = 0; i < 9; i++) e.d[i] = c.d[i];
      end else if (c.flag) begin
        for (int i = 0; i < 9; i++)
          e.d[i] = 32'(qmul(rho, wconst(i == 0 ? 4 : 1, i == 0 ? 9 : (i < 5 ? 9 : 36))));
      end else begin
        fx = qmul(grav_x_q, rho);
        fy = qmul(grav_y_q, rho);
        jx = clamp(clamp(jx) + qmul(fx, half));
        jy = clamp(clamp(jy) + qmul(fy, half));
        ux = qdiv(jx, rho);
        uy = qdiv(jy, rho);
        u2 = clamp(qmul(ux, ux) + qmul(uy, uy));
        uf = clamp(qmul(ux, fx) + qmul(uy, fy));
        coef = clamp(3 * (one - qmul(inv_tau_q, half)));
        for (int i = 0; i < 9; i++) begin
          w = wconst(i == 0 ? 4 : 1, i == 0 ? 9 : (i < 5 ? 9 : 36));
          ud = clamp(DX[i] * ux + DY[i] * uy);
          fd = clamp(DX[i] * fx + DY[i] * fy);
          poly = clamp(one + 3 * ud + qmul(c45, qmul(ud, ud)) - qmul(c15, u2));
          feq = qmul(qmul(rho, w), poly);
          term = clamp(fd - uf + 3 * qmul(ud, fd));
          frc = qmul(coef, qmul(w, term));
          e.d[i] = 32'(clamp(qmul(clamp(one - inv_tau_q), f[i]) + qmul(inv_tau_q, feq) + frc));
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(cell_t got);
      cell_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, actual bad_density %0b", $time, got.flag);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.d[i] !== e.d[i]) begin
          $display("%0t: dist %0d expected %h actual %h", $time, i, e.d[i], got.d[i]);
          errors++;
        end
      if (got.flag !== e.flag) begin
        $display("%0t: bad_density expected %0b actual %0b", $time, e.flag, got.flag);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;   // dist_in_rest, _east, _north, _west, _south, _ne, _nw, _sw, _se
  logic         in_tuser;   // wall_cell
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;  // dist_out_rest .. _se
  logic         out_tuser;  // bad_density
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  collision_scoreboard sb;
  bit hold_off;

  lbm_d2q9_bgk_collision_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(99) < 90) return $urandom_range(2);
    return $urandom_range(40, 5);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offers one word and holds it until the block takes it. Valid stays high
  // afterwards so that the next word can follow in the very next cycle.
  task automatic send_cell(cell_t c, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    for (int i = 0; i < 9; i++) in_tdata[32*i +: 32] <= c.d[i];
    in_tuser <= c.flag;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_cell(c);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Mostly physical cells near rest density; sometimes raw noise.
  function cell_t random_cell();
    cell_t c;
    int    mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 6)
        c.d[i] = 32'sd29826162 + $signed($urandom_range(8000000)) - 32'sd4000000;
      else if (mode < 8)
        c.d[i] = $signed($urandom) >>> $urandom_range(31);
      else
        c.d[i] = $urandom;
    end
    if (mode < 6) c.d[0] = c.d[0] * 4;
    c.flag = ($urandom_range(7) == 0);
    return c;
  endfunction

  task automatic directed_cells();
    cell_t c;
    logic signed [31:0] pat [6];
    pat = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh10000000, 32'shffffffff, 32'sh1};
    foreach (pat[p]) begin
      for (int w = 0; w < 2; w++) begin
        for (int i = 0; i < 9; i++) c.d[i] = pat[p];
        c.flag = (w != 0);
        send_cell(c, 1'b0);
      end
    end
    // Zero density with nonzero distributions passes through, also on a wall.
    for (int i = 0; i < 9; i++) c.d[i] = (i % 2) ? 32'sh1000 : -32'sh1000;
    c.d[0] = 32'sh0;
    c.flag = 1'b0;
    send_cell(c, 1'b0);
    c.flag = 1'b1;
    send_cell(c, 1'b0);
    // Strong flow east saturates rho; the next cell, of tiny rho, saturates velocity.
    for (int i = 0; i < 9; i++) c.d[i] = 32'sh0;
    c.d[1] = 32'sh7fffffff;
    c.d[3] = 32'sh00000010;
    c.flag = 1'b0;
    send_cell(c, 1'b0);
    c.d[1] = -32'sh7fffffff;
    c.d[5] = 32'sh7fffffff;
    send_cell(c, 1'b0);
    for (int k = 0; k < 5; k++) send_cell(random_cell(), 1'b0);
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_cell(random_cell(), 1'b1);
  endtask

  // Receiver: random stalls, plus one long hold-off requested by the sender side.
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      g = ($urandom_range(3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cell_t got;
    if (rst_n && out_tvalid && out_tready) begin
      for (int i = 0; i < 9; i++) got.d[i] = out_tdata[32*i +: 32];
      got.flag = out_tuser;
      sb.check_result(got);
    end
  end

  initial begin
    sb = new();
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_INV_TAU;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_cells();
    random_phase(300);
    wait_drained();

    write_reg(REG_INV_TAU, 32'hffffffff);
    write_reg(REG_GRAV_X, 32'h00010000);
    write_reg(REG_GRAV_Y, 32'hfff00000);
    hold_off = 1'b1;
    random_phase(300);
    wait_drained();

    write_reg(REG_INV_TAU, 32'd0);
    write_reg(REG_GRAV_X, 32'h7fffffff);
    write_reg(REG_GRAV_Y, 32'h80000000);
    random_phase(150);
    wait_drained();

    write_reg(REG_INV_TAU, 32'd536870912);
    write_reg(REG_GRAV_X, 32'h80000000);
    write_reg(REG_GRAV_Y, 32'h7fffffff);
    random_phase(150);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_INV_TAU, $urandom);
      write_reg(REG_GRAV_X, $signed($urandom) >>> $urandom_range(31, 8));
      write_reg(REG_GRAV_Y, $signed($urandom) >>> $urandom_range(31, 8));
      random_phase(100);
      wait_drained();
    end

    if (sb.errors == 0)
      $display("lbm_d2q9_bgk_collision_core test passed");
    else
      $display("lbm_d2q9_bgk_collision_core test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("lbm_d2q9_bgk_collision_core test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* lbm_d2q9_bgk_collision_core.f */
+incdir+hw/rtl
hw/rtl/lbmc_pkg.sv
hw/rtl/lbmc_moments.sv
hw/rtl/lbmc_div.sv
hw/rtl/lbmc_relax.sv
hw/rtl/lbm_d2q9_bgk_collision_core.sv
hw/rtl/lbmc_checker.sv
bench/testbench.sv
